@@ sv/rcp_pkg.sv @@
`timescale 1ns / 1ps

package rcp_pkg;

    // packet layout
    localparam int PKT_DATA_BYTES = 15;
    localparam int PKT_BITS       = PKT_DATA_BYTES * 8;
    localparam int NUM_CHANNELS   = 12;
    localparam int CH_BITS        = 10;
    localparam logic [3:0] LAST_POS = 4'd15;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_CRC_POLY   = 1'b1;

    localparam logic [2:0] PROTO_MSP_V1   = 3'd1;
    localparam logic [2:0] PROTO_MSP_V2   = 3'd2;
    localparam logic [2:0] PROTOCOL_RESET = 3'd0;
    localparam logic [7:0] LINK_POLY_RESET = 8'h07;

    // result status codes
    localparam logic [1:0] ST_FRAME       = 2'd0;
    localparam logic [1:0] ST_CRC_BAD     = 2'd1;
    localparam logic [1:0] ST_PROTO_UNSUP = 2'd2;

    // frame layout
    localparam logic [5:0] V1_HDR_LEN   = 6'd5;
    localparam logic [5:0] V1_LAST_IDX  = 6'd29;
    localparam logic [5:0] V1_CK_FIRST  = 6'd3;
    localparam logic [5:0] V2_HDR_LEN   = 6'd8;
    localparam logic [5:0] V2_LAST_IDX  = 6'd32;
    localparam logic [10:0] CHANNEL_OFFSET = 11'd1000;
    localparam logic [7:0] DVB_S2_POLY  = 8'hD5;

    typedef enum logic [1:0] {
        JOB_MSP_V1,
        JOB_MSP_V2,
        JOB_CRC_BAD,
        JOB_UNSUP
    } t_job_kind;

    typedef struct packed {
        t_job_kind           kind;
        logic [PKT_BITS-1:0] data;
    } t_job;

    // one byte of an MSB-first CRC-8, init and final XOR handled by the caller
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] v1_header(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'h24;
            6'd1:    b = 8'h4d;
            6'd2:    b = 8'h3c;
            6'd3:    b = 8'h18;
            6'd4:    b = 8'hc8;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] v2_header(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'h24;
            6'd1:    b = 8'h58;
            6'd2:    b = 8'h3c;
            6'd4:    b = 8'hc8;
            6'd6:    b = 8'h18;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ sv/rcp_in_if.sv @@
`timescale 1ns / 1ps

interface rcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       packet_start;

    modport source (output valid, output in_byte, output packet_start, input ready);
    modport sink   (input valid, input in_byte, input packet_start, output ready);
endinterface

@@ sv/rcp_out_if.sv @@
`timescale 1ns / 1ps

interface rcp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_last;
    logic [1:0] status;

    modport source (output valid, output out_byte, output frame_last, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input frame_last, input status,
                    output ready);
endinterface

@@ sv/rcp_front.sv @@
`timescale 1ns / 1ps

module rcp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rcp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    rcp_in_if.sink                        i_in,
    input  logic                          i_job_ready,
    output logic                          o_job_valid,
    output rcp_pkg::t_job                 o_job
);
    import rcp_pkg::*;

    logic [2:0] r_protocol;
    logic [7:0] r_poly;
    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic [7:0] r_store [PKT_DATA_BYTES];

    logic       accept;
    logic [3:0] pos_eff;
    logic [7:0] crc_eff;
    logic       is_check_byte;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol <= PROTOCOL_RESET;
            r_poly     <= LINK_POLY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PROTOCOL_SELECT: r_protocol <= i_cfg_data[2:0];
                CFG_LINK_CRC_POLY:   r_poly     <= i_cfg_data;
                default:             r_poly     <= r_poly;
            endcase
        end
    end

    // a start mark realigns position and restarts the CRC
    assign i_in.ready    = i_job_ready;
    assign accept        = i_in.valid && i_in.ready;
    assign pos_eff       = i_in.packet_start ? 4'd0 : r_pos;
    assign crc_eff       = i_in.packet_start ? 8'd0 : r_crc;
    assign is_check_byte = (pos_eff == LAST_POS);

    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        if (accept) begin
            if (is_check_byte) begin
                n_pos = 4'd0;
                n_crc = 8'd0;
            end else begin
                n_pos = pos_eff + 4'd1;
                n_crc = crc8_byte(crc_eff, i_in.in_byte, r_poly);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 4'd0;
            r_crc <= 8'd0;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    // hold packet bytes 0..14
    always_ff @(posedge i_clk) begin
        if (accept && !is_check_byte) begin
            r_store[pos_eff] <= i_in.in_byte;
        end
    end

    // classify the packet on its check byte
    always_comb begin
        o_job_valid = accept && is_check_byte;
        for (int j = 0; j < PKT_DATA_BYTES; j++) begin
            o_job.data[8*j +: 8] = r_store[j];
        end
        if (crc_eff != i_in.in_byte) begin
            o_job.kind = JOB_CRC_BAD;
        end else if (r_protocol == PROTO_MSP_V1) begin
            o_job.kind = JOB_MSP_V1;
        end else if (r_protocol == PROTO_MSP_V2) begin
            o_job.kind = JOB_MSP_V2;
        end else begin
            o_job.kind = JOB_UNSUP;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= LAST_POS) && (r_pos != 4'd0 || r_crc == 8'd0))
        else $error("front position or CRC out of step");

endmodule

@@ sv/rcp_queue.sv @@
`timescale 1ns / 1ps

module rcp_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rcp_pkg::t_job i_job,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output rcp_pkg::t_job o_job,
    input  logic          i_pop
);
    import rcp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_cnt != CNT_FULL);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_job        = r_mem[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_push_ready))
        else $error("job pushed into a full queue");

    a_cnt_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_FULL) && ((r_cnt != '0 && r_cnt != CNT_FULL) || r_wp == r_rp))
        else $error("queue count and pointers disagree");

endmodule

@@ sv/rcp_back.sv @@
`timescale 1ns / 1ps

module rcp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  rcp_pkg::t_job i_job,
    output logic          o_job_pop,
    rcp_out_if.source     o_out
);
    import rcp_pkg::*;

    logic                r_busy;
    t_job_kind           r_kind;
    logic [PKT_BITS-1:0] r_data;
    logic [5:0]          r_idx;
    logic [7:0]          r_ck;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic [1:0] r_out_status;

    logic         out_free;
    logic         step;
    logic [5:0]   off;
    logic [3:0]   ch_sel;
    logic [9:0]   ch_val;
    logic [10:0]  ch_sum;
    logic [7:0]   ch_byte;
    logic [7:0]   gen_byte;
    logic         gen_last;
    logic [1:0]   gen_status;
    logic [7:0]   n_ck;

    assign out_free  = !r_out_valid || o_out.ready;
    assign step      = r_busy && out_free;
    assign o_job_pop = !r_busy;

    // pick the channel slice for the current byte, offset it
    always_comb begin
        off = r_idx - ((r_kind == JOB_MSP_V2) ? V2_HDR_LEN : V1_HDR_LEN);
        ch_sel  = off[4:1];
        ch_val  = r_data[ch_sel*CH_BITS +: CH_BITS];
        ch_sum  = {1'b0, ch_val} + CHANNEL_OFFSET;
        ch_byte = off[0] ? ch_sum[7:0] : {5'd0, ch_sum[10:8]};
    end

    // generate one frame byte and, for MSP frames, fold it into the checksum
    always_comb begin
        gen_byte   = 8'd0;
        gen_last   = 1'b1;
        gen_status = ST_FRAME;
        n_ck       = r_ck;
        case (r_kind)
            JOB_MSP_V1: begin
                if (r_idx < V1_HDR_LEN) begin
                    gen_byte = v1_header(r_idx);
                end else if (r_idx < V1_LAST_IDX) begin
                    gen_byte = ch_byte;
                end else begin
                    gen_byte = r_ck;
                end
                gen_last = (r_idx == V1_LAST_IDX);
                if (r_idx >= V1_CK_FIRST && r_idx < V1_LAST_IDX) begin
                    n_ck = r_ck ^ gen_byte;
                end
            end
            JOB_MSP_V2: begin
                if (r_idx < V2_HDR_LEN) begin
                    gen_byte = v2_header(r_idx);
                end else if (r_idx < V2_LAST_IDX) begin
                    gen_byte = ch_byte;
                end else begin
                    gen_byte = r_ck;
                end
                gen_last = (r_idx == V2_LAST_IDX);
                if (r_idx < V2_LAST_IDX) begin
                    n_ck = crc8_byte(r_ck, gen_byte, DVB_S2_POLY);
                end
            end
            JOB_CRC_BAD: gen_status = ST_CRC_BAD;
            JOB_UNSUP:   gen_status = ST_PROTO_UNSUP;
            default:     gen_status = ST_PROTO_UNSUP;
        endcase
    end

    // job sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (step && gen_last) begin
            r_busy <= 1'b0;
        end else if (!r_busy && i_job_valid) begin
            r_busy <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_job_valid) begin
            r_kind <= i_job.kind;
            r_data <= i_job.data;
            r_idx  <= 6'd0;
            r_ck   <= 8'd0;
        end else if (step) begin
            r_idx <= r_idx + 6'd1;
            r_ck  <= n_ck;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte   <= gen_byte;
            r_out_last   <= gen_last;
            r_out_status <= gen_status;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.frame_last = r_out_last;
    assign o_out.status     = r_out_status;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= V2_LAST_IDX) &&
                   ((r_kind != JOB_CRC_BAD && r_kind != JOB_UNSUP) || r_idx == 6'd0))
        else $error("frame byte index out of range");

    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_FRAME) |-> (r_out_last && r_out_byte == 8'd0))
        else $error("status word is not a lone zero word");

endmodule

@@ sv/rc_packet_to_msp_frame_core.sv @@
`timescale 1ns / 1ps

// Radio control packet to MSP_SET_RAW_RC frame generator.
// Input channel i_in: one packet byte per word, packet_start marks byte 0.
// Bytes 0..14 are stored and CRC-8 checked against byte 15 (poly from
// register 1). Register 0 picks MSPv1 (30-byte frame) or MSPv2 (33-byte).
// Output channel o_out: one frame byte per word, frame_last on the final
// word of a packet; a bad CRC or unsupported protocol gives one zero word
// with a nonzero status.
// Throughput: one input word per cycle while the job queue has room, one
// output word per cycle while o_out is ready; a good packet's 16 input
// words yield 30 or 33 output words, so the output side sets the
// sustained rate. The queue holds QDEPTH finished packets.
// The first frame word passes the queue, the generator's job registers
// and output register after the check byte; the generator idles between
// frames to load a job. When o_out stalls, the output register holds and
// the queue fills; the input then stalls on every word while it is full.
// Reset (synchronous): position and CRC cleared, queue emptied, protocol 0
// (unsupported), link polynomial 0x07. No clearing pass is needed.
module rc_packet_to_msp_frame_core #(
    parameter int QDEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rcp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    rcp_in_if.sink                        i_in,
    rcp_out_if.source                     o_out
);
    import rcp_pkg::*;

    logic push_valid;
    logic push_ready;
    t_job push_job;
    logic pop_valid;
    logic pop;
    t_job pop_job;

    rcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_job_ready (push_ready),
        .o_job_valid (push_valid),
        .o_job       (push_job)
    );

    rcp_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .i_job        (push_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_job        (pop_job),
        .i_pop        (pop)
    );

    rcp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .i_job       (pop_job),
        .o_job_pop   (pop),
        .o_out       (o_out)
    );

endmodule
